/* rtl/core/tmpl_pkg.sv */
package tmpl_pkg;

    // register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAFE_RATIO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER     = 2'd2;

    localparam int RATIO_W = 16;
    localparam int MP_W    = 15;
    localparam int CMD_W   = 16;

    localparam logic [RATIO_W-1:0] STRAFE_RATIO_RST  = 16'd16384;
    localparam logic [RATIO_W-1:0] REVERSE_RATIO_RST = 16'd16384;
    localparam logic [MP_W-1:0]    MAX_POWER_RST     = 15'd4096;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_YAW  = 1'b1;

    // intermediate widths
    localparam int MIX_W    = 22;   // signed pair values, |v| < 2^20
    localparam int MAG_W    = 21;   // unsigned magnitude, also divider remainder
    localparam int DIV_BITS = 16;   // quotient bits, scale is Q0.16
    localparam int SCALE_W  = 17;   // scale incl. the exact 1.0 code
    localparam int SS_W     = 17;   // scaled 16-bit command, |v| <= 32768

    localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h10000;

    typedef struct packed {
        logic [RATIO_W-1:0] strafe_ratio;
        logic [RATIO_W-1:0] reverse_ratio;
        logic [MP_W-1:0]    max_power;
    } cfg_t;

    typedef struct packed {
        logic                    kind;
        logic signed [CMD_W-1:0] forward_cmd;
        logic signed [CMD_W-1:0] strafe_cmd;
        logic signed [CMD_W-1:0] dive_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
    } in_item_t;

    typedef struct packed {
        logic signed [CMD_W-1:0] left_forward_drive;
        logic signed [CMD_W-1:0] right_forward_drive;
        logic signed [CMD_W-1:0] left_strafe_drive;
        logic signed [CMD_W-1:0] right_strafe_drive;
        logic signed [CMD_W-1:0] front_dive_drive;
        logic signed [CMD_W-1:0] rear_dive_drive;
    } out_item_t;

    // per-item payload carried alongside the divider
    typedef struct packed {
        logic                    kind;
        logic signed [MIX_W-1:0] lf;
        logic signed [MIX_W-1:0] rf;
        logic signed [CMD_W-1:0] str;
        logic signed [CMD_W-1:0] dive;
        logic signed [MIX_W-1:0] ylf;
        logic signed [MIX_W-1:0] yrf;
    } mix_t;

    // front end -> divider
    typedef struct packed {
        mix_t             mix;
        logic             need;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] rem;
    } div_t;

    // divider -> back end
    typedef struct packed {
        mix_t                mix;
        logic                need;
        logic [DIV_BITS-1:0] quo;
    } scl_t;

    function automatic logic signed [CMD_W-1:0] sat16(input logic signed [MIX_W-1:0] v);
        logic signed [CMD_W-1:0] r;
        if (v > 22'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -22'sd32768)
        begin
            r = -16'sh8000;
        end
        else
        begin
            r = v[CMD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/tmpl_front.sv */
module tmpl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  tmpl_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  tmpl_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output tmpl_pkg::div_t    out_data
);
    import tmpl_pkg::*;

    localparam int S1_W = 19;

    // stall chain
    logic en1, en2, en3, en4;

    // stage 1: strafe * strafe_ratio, yaw pair
    logic                    v1_reg;
    logic                    k1_reg;
    logic signed [CMD_W-1:0] fwd1_reg, str1_reg, dive1_reg;
    logic signed [S1_W-1:0]  s1_reg, s1_next;
    logic signed [MIX_W-1:0] ylf1_reg, yrf1_reg, ylf_next, yrf_next;

    logic signed [32:0]      sp, spr, yp, ypr;
    logic signed [S1_W-1:0]  ypq;
    logic signed [MIX_W-1:0] yaw_w, ypq_w;

    assign sp   = in_data.strafe_cmd * $signed({1'b0, cfg.strafe_ratio});
    assign spr  = sp + 33'sd8192;
    assign s1_next = spr[32:14];
    assign yp   = in_data.yaw_cmd * $signed({1'b0, cfg.reverse_ratio});
    assign ypr  = yp + 33'sd8192;
    assign ypq  = ypr[32:14];
    assign yaw_w = in_data.yaw_cmd;
    assign ypq_w = ypq;
    assign ylf_next = (in_data.yaw_cmd < 0) ? yaw_w : ypq_w;
    assign yrf_next = (in_data.yaw_cmd < 0) ? -ypq_w : -yaw_w;

    // stage 2: reciprocal pair of the strafe correction
    logic                    v2_reg;
    logic                    k2_reg;
    logic signed [CMD_W-1:0] fwd2_reg, str2_reg, dive2_reg;
    logic signed [MIX_W-1:0] cl2_reg, cr2_reg, cl_next, cr_next;
    logic signed [MIX_W-1:0] ylf2_reg, yrf2_reg;

    logic signed [35:0]      cp, cpr;
    logic signed [MIX_W-1:0] cpq, s1_w;

    assign cp   = s1_reg * $signed({1'b0, cfg.reverse_ratio});
    assign cpr  = cp + 36'sd8192;
    assign cpq  = cpr[35:14];
    assign s1_w = s1_reg;
    assign cl_next = (s1_reg < 0) ? s1_w : cpq;
    assign cr_next = (s1_reg < 0) ? -cpq : -s1_w;

    // stage 3: add forward
    logic v3_reg;
    mix_t mix3_reg, mix3_next;
    logic signed [MIX_W-1:0] fwd2_w;

    assign fwd2_w = fwd2_reg;

    always_comb
    begin
        mix3_next.kind = k2_reg;
        mix3_next.lf   = cl2_reg + fwd2_w;
        mix3_next.rf   = cr2_reg + fwd2_w;
        mix3_next.str  = str2_reg;
        mix3_next.dive = dive2_reg;
        mix3_next.ylf  = ylf2_reg;
        mix3_next.yrf  = yrf2_reg;
    end

    // stage 4: magnitude and limit compare
    logic  v4_reg;
    div_t  d4_reg, d4_next;
    logic signed [MIX_W-1:0] al, ar;
    logic [MAG_W-1:0] ml, mr, mm;

    assign al = (mix3_reg.lf < 0) ? -mix3_reg.lf : mix3_reg.lf;
    assign ar = (mix3_reg.rf < 0) ? -mix3_reg.rf : mix3_reg.rf;
    assign ml = al[MAG_W-1:0];
    assign mr = ar[MAG_W-1:0];
    assign mm = (ml > mr) ? ml : mr;

    always_comb
    begin
        d4_next.mix  = mix3_reg;
        d4_next.mag  = mm;
        d4_next.need = mm > MAG_W'(cfg.max_power);
        d4_next.rem  = MAG_W'(cfg.max_power);
    end

    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            k1_reg    <= in_data.kind;
            fwd1_reg  <= in_data.forward_cmd;
            str1_reg  <= in_data.strafe_cmd;
            dive1_reg <= in_data.dive_cmd;
            s1_reg    <= s1_next;
            ylf1_reg  <= ylf_next;
            yrf1_reg  <= yrf_next;
        end
        if (en2)
        begin
            k2_reg    <= k1_reg;
            fwd2_reg  <= fwd1_reg;
            str2_reg  <= str1_reg;
            dive2_reg <= dive1_reg;
            cl2_reg   <= cl_next;
            cr2_reg   <= cr_next;
            ylf2_reg  <= ylf1_reg;
            yrf2_reg  <= yrf1_reg;
        end
        if (en3)
        begin
            mix3_reg <= mix3_next;
        end
        if (en4)
        begin
            d4_reg <= d4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = d4_reg;

endmodule

/* rtl/core/tmpl_div.sv */
module tmpl_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  tmpl_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output tmpl_pkg::scl_t out_data
);
    import tmpl_pkg::*;

    localparam int LAST = DIV_BITS - 1;

    // one quotient bit per stage, remainder starts at max_power
    logic                v_reg    [DIV_BITS];
    logic [MAG_W-1:0]    r_reg    [DIV_BITS];
    logic [MAG_W-1:0]    r_next   [DIV_BITS];
    logic [DIV_BITS-1:0] q_reg    [DIV_BITS];
    logic [DIV_BITS-1:0] q_next   [DIV_BITS];
    logic [MAG_W-1:0]    d_reg    [DIV_BITS];
    logic [MAG_W-1:0]    d_next   [DIV_BITS];
    logic                need_reg [DIV_BITS];
    logic                need_next[DIV_BITS];
    mix_t                mix_reg  [DIV_BITS];
    mix_t                mix_next [DIV_BITS];
    logic                v_next   [DIV_BITS];
    logic                en       [DIV_BITS];

    always_comb
    begin
        en[LAST] = !v_reg[LAST] || !out_stall;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_stall = !en[0];

    always_comb
    begin
        logic [MAG_W-1:0]    rp;
        logic [DIV_BITS-1:0] qp;
        logic [MAG_W:0]      t;
        logic [MAG_W:0]      diff;
        logic                ge;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            if (i == 0)
            begin
                v_next[i]    = in_valid;
                rp           = in_data.rem;
                qp           = '0;
                d_next[i]    = in_data.mag;
                need_next[i] = in_data.need;
                mix_next[i]  = in_data.mix;
            end
            else
            begin
                v_next[i]    = v_reg[i-1];
                rp           = r_reg[i-1];
                qp           = q_reg[i-1];
                d_next[i]    = d_reg[i-1];
                need_next[i] = need_reg[i-1];
                mix_next[i]  = mix_reg[i-1];
            end
            t         = {rp, 1'b0};
            diff      = t - {1'b0, d_next[i]};
            ge        = t >= {1'b0, d_next[i]};
            r_next[i] = ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
            q_next[i] = {qp[DIV_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_BITS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < DIV_BITS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_BITS; i++)
        begin
            if (en[i])
            begin
                r_reg[i]    <= r_next[i];
                q_reg[i]    <= q_next[i];
                d_reg[i]    <= d_next[i];
                need_reg[i] <= need_next[i];
                mix_reg[i]  <= mix_next[i];
            end
        end
    end

    assign out_valid     = v_reg[LAST];
    assign out_data.mix  = mix_reg[LAST];
    assign out_data.need = need_reg[LAST];
    assign out_data.quo  = q_reg[LAST];

endmodule

/* rtl/core/tmpl_back.sv */
module tmpl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tmpl_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  tmpl_pkg::scl_t      in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tmpl_pkg::out_item_t out_data
);
    import tmpl_pkg::*;

    logic enA, enB, enC;

    // stage A: apply scale
    logic                    vA_reg, kA_reg;
    logic signed [MIX_W-1:0] lfA_reg, rfA_reg, ylfA_reg, yrfA_reg;
    logic signed [SS_W-1:0]  ssA_reg, dvA_reg, ss_next, dv_next;
    logic signed [MIX_W-1:0] lf_next, rf_next;

    logic [SCALE_W-1:0]      scale;
    logic signed [SCALE_W:0] sc;
    logic signed [39:0]      lp, lpr, rp, rpr;
    logic signed [33:0]      spp, sppr, dp, dpr;

    assign scale = in_data.need ? {1'b0, in_data.quo} : SCALE_ONE;
    assign sc    = $signed({1'b0, scale});
    assign lp    = in_data.mix.lf * sc;
    assign rp    = in_data.mix.rf * sc;
    assign spp   = in_data.mix.str * sc;
    assign dp    = in_data.mix.dive * sc;
    assign lpr   = lp + 40'sd32768;
    assign rpr   = rp + 40'sd32768;
    assign sppr  = spp + 34'sd32768;
    assign dpr   = dp + 34'sd32768;
    // scale <= 1.0, so results never grow
    assign lf_next = lpr[37:16];
    assign rf_next = rpr[37:16];
    assign ss_next = sppr[32:16];
    assign dv_next = dpr[32:16];

    // stage B: strafe pair and command select
    logic                    vB_reg;
    logic signed [MIX_W-1:0] lfB_reg, rfB_reg, lsB_reg, rsB_reg, dvB_reg;
    logic signed [MIX_W-1:0] lfB_next, rfB_next, lsB_next, rsB_next, dvB_next;

    logic signed [33:0]      qp, qpr;
    logic signed [MIX_W-1:0] qq, ss_w, dv_w, ls_m, rs_m;
    logic                    yaw;

    assign qp   = ssA_reg * $signed({1'b0, cfg.reverse_ratio});
    assign qpr  = qp + 34'sd8192;
    // 20-bit rounded product, sign-extended to the pair width
    assign qq   = {{(MIX_W-20){qpr[33]}}, qpr[33:14]};
    assign ss_w = ssA_reg;
    assign dv_w = dvA_reg;
    assign ls_m = (ssA_reg < 0) ? ss_w : qq;
    assign rs_m = (ssA_reg < 0) ? -qq : -ss_w;
    assign yaw  = (kA_reg == KIND_YAW);

    assign lfB_next = yaw ? ylfA_reg : lfA_reg;
    assign rfB_next = yaw ? yrfA_reg : rfA_reg;
    assign lsB_next = yaw ? '0 : ls_m;
    assign rsB_next = yaw ? '0 : rs_m;
    assign dvB_next = yaw ? '0 : dv_w;

    // stage C: saturate into the output register
    logic      vC_reg;
    out_item_t oC_reg, oC_next;
    logic signed [CMD_W-1:0] dv_sat;

    assign dv_sat = sat16(dvB_reg);

    always_comb
    begin
        oC_next.left_forward_drive  = sat16(lfB_reg);
        oC_next.right_forward_drive = sat16(rfB_reg);
        oC_next.left_strafe_drive   = sat16(lsB_reg);
        oC_next.right_strafe_drive  = sat16(rsB_reg);
        oC_next.front_dive_drive    = dv_sat;
        oC_next.rear_dive_drive     = dv_sat;
    end

    assign enC = !vC_reg || !out_stall;
    assign enB = !vB_reg || enC;
    assign enA = !vA_reg || enB;
    assign in_stall = !enA;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vA_reg <= 1'b0;
            vB_reg <= 1'b0;
            vC_reg <= 1'b0;
        end
        else
        begin
            if (enA)
            begin
                vA_reg <= in_valid;
            end
            if (enB)
            begin
                vB_reg <= vA_reg;
            end
            if (enC)
            begin
                vC_reg <= vB_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enA)
        begin
            kA_reg   <= in_data.mix.kind;
            lfA_reg  <= lf_next;
            rfA_reg  <= rf_next;
            ssA_reg  <= ss_next;
            dvA_reg  <= dv_next;
            ylfA_reg <= in_data.mix.ylf;
            yrfA_reg <= in_data.mix.yrf;
        end
        if (enB)
        begin
            lfB_reg <= lfB_next;
            rfB_reg <= rfB_next;
            lsB_reg <= lsB_next;
            rsB_reg <= rsB_next;
            dvB_reg <= dvB_next;
        end
        if (enC)
        begin
            oC_reg <= oC_next;
        end
    end

    assign out_valid = vC_reg;
    assign out_data  = oC_reg;

endmodule

/* rtl/core/thruster_mix_with_power_limit.sv */
// Thruster mixer with forward power limit.
//
// Input channel (in_valid / in_stall / in_data): one motion command per item,
// either a move (forward, strafe, dive) or a yaw command. Output channel
// (out_valid / out_stall / out_data): one item of six Q3.12 drive values for
// every command, in order. Config channel (cfg_valid / cfg_ready, cfg_index,
// cfg_data): strafe_ratio, reverse_ratio, max_power; always ready. Unknown
// indexes are dropped. The user must write it only while no command is in
// flight; the block itself does not enforce this.
// The pipeline has 4 front stages (ratio products, pair, magnitude),
// 16 divider stages (one quotient bit each, forming max_power / magnitude),
// and 3 back stages (scale products, strafe pair, saturation). Throughput is
// one item per cycle unless stalled; the bit-per-stage divider sets the depth.
//
// Reset clears every valid bit and loads the register defaults (ratios 1.0,
// max_power 1.0). When out_stall holds, stages fill their empty slots first;
// in_stall rises only once every stage holds an item.
module thruster_mix_with_power_limit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmpl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tmpl_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tmpl_pkg::out_item_t            out_data
);
    import tmpl_pkg::*;

    // configuration registers
    logic [RATIO_W-1:0] strafe_ratio_reg;
    logic [RATIO_W-1:0] reverse_ratio_reg;
    logic [MP_W-1:0]    max_power_reg;
    cfg_t               cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strafe_ratio_reg  <= STRAFE_RATIO_RST;
            reverse_ratio_reg <= REVERSE_RATIO_RST;
            max_power_reg     <= MAX_POWER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STRAFE_RATIO:  strafe_ratio_reg  <= cfg_data;
                CFG_REVERSE_RATIO: reverse_ratio_reg <= cfg_data;
                CFG_MAX_POWER:     max_power_reg     <= cfg_data[MP_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.strafe_ratio  = strafe_ratio_reg;
    assign cfg.reverse_ratio = reverse_ratio_reg;
    assign cfg.max_power     = max_power_reg;

    // front end -> divider -> back end
    logic  fd_valid, fd_stall;
    div_t  fd_data;
    logic  db_valid, db_stall;
    scl_t  db_data;

    tmpl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (fd_valid),
        .out_stall (fd_stall),
        .out_data  (fd_data)
    );

    tmpl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fd_valid),
        .in_stall  (fd_stall),
        .in_data   (fd_data),
        .out_valid (db_valid),
        .out_stall (db_stall),
        .out_data  (db_data)
    );

    tmpl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (db_valid),
        .in_stall  (db_stall),
        .in_data   (db_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // input backpressure only when the pipe is full and the output is held
    a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output not held");

    a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output stage");

    a_divider_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (db_valid && !db_stall) |-> !(fd_stall && !fd_valid))
        else $error("divider stalls front end without holding an item");

endmodule
